// ----- rtl/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-checked frame receiver package
// Widths, codes, register indexes, shared types and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ERR_W     = 32;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] DEV_TYPE_RST    = 8'h40;
  localparam logic [BYTE_W-1:0] DEV_ADDR_RST    = 8'h01;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h55;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_TYPE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 8'd3;

  // Frame status codes
  localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  // Parser step: the byte that the parser waits for next
  typedef enum logic [STEP_W-1:0] {
    STEP_HUNT      = 4'd0,
    STEP_TYPE      = 4'd1,
    STEP_ADDR      = 4'd2,
    STEP_CMD       = 4'd3,
    STEP_LEN       = 4'd4,
    STEP_PAYLOAD   = 4'd5,
    STEP_CRC_LOW   = 4'd6,
    STEP_CRC_HIGH  = 4'd7,
    STEP_END       = 4'd8
  } step_e;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] dev_type;
    logic [BYTE_W-1:0] dev_addr;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] frame_status;
    logic [STEP_W-1:0]   stage;
    logic [BYTE_W-1:0]   frame_cmd;
    logic [BYTE_W-1:0]   frame_len;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   payload_index;
    logic [ERR_W-1:0]    error_count;
  } res_t;

  // CRC-16 XMODEM, one byte, MSB first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crcfr_ifs.sv -----
// ----------------------------------------------------------------------------
// CRC-checked frame receiver channels
// Valid/ready channels for received bytes, parse results and register writes.
// ----------------------------------------------------------------------------
interface crcfr_rx_if;
  import crcfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
  import crcfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] frame_status;
  logic [STEP_W-1:0]   stage;
  logic [BYTE_W-1:0]   frame_cmd;
  logic [BYTE_W-1:0]   frame_len;
  logic                payload_valid;
  logic [BYTE_W-1:0]   payload_byte;
  logic [BYTE_W-1:0]   payload_index;
  logic [ERR_W-1:0]    error_count;

  modport source (output valid, output frame_status, output stage, output frame_cmd,
                  output frame_len, output payload_valid, output payload_byte,
                  output payload_index, output error_count, input ready);
  modport sink   (input valid, input frame_status, input stage, input frame_cmd,
                  input frame_len, input payload_valid, input payload_byte,
                  input payload_index, input error_count, output ready);
endinterface

interface crcfr_cfg_if;
  import crcfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crcfr_parser.sv -----
// ----------------------------------------------------------------------------
// CRC-checked frame receiver parser
// Frame state machine, running CRC, payload index and bad-frame counter.
// ----------------------------------------------------------------------------
module crcfr_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic [crcfr_pkg::BYTE_W-1:0] byte_i,
  input  crcfr_pkg::cfg_t          cfg_i,
  output crcfr_pkg::res_t          res_o
);
  import crcfr_pkg::*;

  step_e             step_q, step_d;
  logic [BYTE_W-1:0] left_q, left_d;
  logic [BYTE_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [BYTE_W-1:0] low_q, low_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [CRC_W-1:0]  crc_step;
  logic              end_ok;

  assign crc_step = crc_feed(crc_q, byte_i);
  assign end_ok   = (byte_i == cfg_i.end_byte) && (low_q == 8'd1);

  // Next state
  always_comb begin
    step_d = step_q;
    left_d = left_q;
    idx_d  = idx_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    crc_d  = crc_q;
    low_d  = low_q;
    err_d  = err_q;
    if (adv_i) begin
      case (step_q)
        STEP_HUNT: begin
          if (byte_i == cfg_i.start_byte) begin
            crc_d  = crc_feed('0, byte_i);
            step_d = STEP_TYPE;
          end
        end
        STEP_TYPE: begin
          if (byte_i == cfg_i.dev_type) begin
            crc_d  = crc_step;
            step_d = STEP_ADDR;
          end else begin
            step_d = STEP_HUNT;
          end
        end
        STEP_ADDR: begin
          if (byte_i == cfg_i.dev_addr) begin
            crc_d  = crc_step;
            idx_d  = '0;
            step_d = STEP_CMD;
          end else begin
            step_d = STEP_HUNT;
          end
        end
        STEP_CMD: begin
          cmd_d  = byte_i;
          crc_d  = crc_step;
          step_d = STEP_LEN;
        end
        STEP_LEN: begin
          len_d  = byte_i;
          left_d = byte_i;
          crc_d  = crc_step;
          step_d = STEP_PAYLOAD;
        end
        STEP_PAYLOAD: begin
          if (left_q != '0) begin
            idx_d  = idx_q + 8'd1;
            left_d = left_q - 8'd1;
            crc_d  = crc_step;
          end else begin
            low_d  = byte_i;
            step_d = STEP_CRC_HIGH;
          end
        end
        STEP_CRC_LOW: begin
          low_d  = byte_i;
          step_d = STEP_CRC_HIGH;
        end
        STEP_CRC_HIGH: begin
          // keep only the match flag for the end byte check
          low_d  = {7'd0, ({byte_i, low_q} == crc_q)};
          step_d = STEP_END;
        end
        STEP_END: begin
          if (!end_ok) begin
            err_d = err_q + 32'd1;
          end
          idx_d  = '0;
          step_d = STEP_HUNT;
        end
        default: begin
          step_d = STEP_HUNT;
        end
      endcase
    end
  end

  // Result for the byte in flight
  always_comb begin
    res_o               = '0;
    res_o.stage         = step_d;
    res_o.frame_cmd     = cmd_d;
    res_o.frame_len     = len_d;
    res_o.error_count   = err_d;
    if (step_q == STEP_END) begin
      res_o.frame_status = end_ok ? STATUS_GOOD : STATUS_BAD;
    end
    if ((step_q == STEP_PAYLOAD) && (left_q != '0)) begin
      res_o.payload_valid = 1'b1;
      res_o.payload_byte  = byte_i;
      res_o.payload_index = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_HUNT;
      left_q <= '0;
      idx_q  <= '0;
      cmd_q  <= '0;
      len_q  <= '0;
      crc_q  <= '0;
      low_q  <= '0;
      err_q  <= '0;
    end else begin
      step_q <= step_d;
      left_q <= left_d;
      idx_q  <= idx_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      low_q  <= low_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- rtl/crc_checked_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Parses start/type/address/command/length/payload/CRC/end frames byte by byte.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result per
// byte. Throughput is one byte per clock while results are taken; a byte's
// result passes the input register, then the result register, with one
// CRC-16 byte step and a compare between them. A stalled result still lets one
// more byte into the input register; after that the input waits until the
// result is taken. Registers are written through the configuration channel,
// which is always ready; write only while idle.
module crc_checked_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfr_rx_if.sink    rx_i,
  crcfr_res_if.source res_o,
  crcfr_cfg_if.sink   cfg_i
);
  import crcfr_pkg::*;

  cfg_t              cfg_q;
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_vld_q;
  res_t              res_q;
  res_t              res_d;
  logic              adv;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= START_BYTE_RST;
      cfg_q.dev_type   <= DEV_TYPE_RST;
      cfg_q.dev_addr   <= DEV_ADDR_RST;
      cfg_q.end_byte   <= END_BYTE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_BYTE: cfg_q.start_byte <= cfg_i.data;
        CFG_DEV_TYPE:   cfg_q.dev_type   <= cfg_i.data;
        CFG_DEV_ADDR:   cfg_q.dev_addr   <= cfg_i.data;
        CFG_END_BYTE:   cfg_q.end_byte   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Advance the byte in the input register when the result slot frees up
  assign adv        = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  crcfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.frame_status  = res_q.frame_status;
  assign res_o.stage         = res_q.stage;
  assign res_o.frame_cmd     = res_q.frame_cmd;
  assign res_o.frame_len     = res_q.frame_len;
  assign res_o.payload_valid = res_q.payload_valid;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.payload_index = res_q.payload_index;
  assign res_o.error_count   = res_q.error_count;

endmodule

// ----- rtl/crcfr_checker.sv -----
// ----------------------------------------------------------------------------
// CRC-checked frame receiver checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module crcfr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [crcfr_pkg::STATUS_W-1:0] frame_status_i,
  input logic [crcfr_pkg::STEP_W-1:0]   stage_i,
  input logic                           payload_valid_i,
  input logic [crcfr_pkg::BYTE_W-1:0]   payload_byte_i,
  input logic [crcfr_pkg::BYTE_W-1:0]   payload_index_i,
  input logic [crcfr_pkg::ERR_W-1:0]    error_count_i
);
  import crcfr_pkg::*;

  // A finished frame always drops back to hunting
  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (frame_status_i != STATUS_BUSY) |-> (stage_i == STEP_HUNT))
    else $error("frame ended without returning to hunt");

  // A payload byte stays in the payload step and ends nothing
  a_payload_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && payload_valid_i |->
      (stage_i == STEP_PAYLOAD) && (frame_status_i == STATUS_BUSY))
    else $error("payload byte outside the payload step");

  // Non-payload results carry zero payload fields
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !payload_valid_i |->
      (payload_byte_i == '0) && (payload_index_i == '0))
    else $error("payload fields set without payload byte");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(frame_status_i) &&
      $stable(stage_i) && $stable(error_count_i))
    else $error("stalled result changed");

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .frame_status_i  (res_o.frame_status),
  .stage_i         (res_o.stage),
  .payload_valid_i (res_o.payload_valid),
  .payload_byte_i  (res_o.payload_byte),
  .payload_index_i (res_o.payload_index),
  .error_count_i   (res_o.error_count)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds framed and broken byte streams under several register settings and
// compares every parse result against an in-bench model of the frame parser.
// ----------------------------------------------------------------------------
module tb;
  import crcfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned TAIL_ITEMS    = 100;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned PHASE_ITEMS   = 130;

  typedef enum int {
    FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_BAD_TYPE, FR_BAD_ADDR, FR_CUT
  } frame_kind_e;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    val;
  } plan_item_t;

  typedef struct {
    step_e             step;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] crc_lo;
    logic              crc_ok;
    logic [CRC_W-1:0]  crc;
    logic [ERR_W-1:0]  bad;
  } parser_t;

  logic clk;
  logic rst_n;

  crcfr_rx_if  rx_if ();
  crcfr_res_if res_if ();
  crcfr_cfg_if cfg_if ();

  crc_checked_frame_receiver u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  plan_item_t  byte_plan_q[$];
  res_t        parse_results_q[$];
  parser_t     psr;
  cfg_t        cfg_m;
  cfg_t        plan_cfg;
  int unsigned rx_taken;
  int unsigned settled;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        calm;
  logic        long_hold;

  // Clock, with every block input known from time zero
  initial begin : clock_gen
    clk          = 1'b0;
    rst_n        = 1'b0;
    rx_if.valid  = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : reset_gen
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // CRC-16 XMODEM, one bit of the byte per iteration, MSB first
  function automatic logic [CRC_W-1:0] crc16_byte(logic [CRC_W-1:0] crc,
                                                  logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ b[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Advance the parser model by one byte and return the result it reports
  function automatic res_t parse_byte(logic [BYTE_W-1:0] b);
    res_t r;
    r = '0;
    r.frame_status = STATUS_BUSY;
    case (psr.step)
      STEP_HUNT: begin
        if (b == cfg_m.start_byte) begin
          psr.crc  = crc16_byte('0, b);
          psr.step = STEP_TYPE;
        end
      end
      STEP_TYPE: begin
        if (b == cfg_m.dev_type) begin
          psr.crc  = crc16_byte(psr.crc, b);
          psr.step = STEP_ADDR;
        end else begin
          psr.step = STEP_HUNT;
        end
      end
      STEP_ADDR: begin
        if (b == cfg_m.dev_addr) begin
          psr.crc  = crc16_byte(psr.crc, b);
          psr.idx  = '0;
          psr.step = STEP_CMD;
        end else begin
          psr.step = STEP_HUNT;
        end
      end
      STEP_CMD: begin
        psr.cmd  = b;
        psr.crc  = crc16_byte(psr.crc, b);
        psr.step = STEP_LEN;
      end
      STEP_LEN: begin
        psr.len  = b;
        psr.left = b;
        psr.crc  = crc16_byte(psr.crc, b);
        psr.step = STEP_PAYLOAD;
      end
      STEP_PAYLOAD: begin
        if (psr.left != 0) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = psr.idx;
          psr.idx  = psr.idx + 8'd1;
          psr.left = psr.left - 8'd1;
          psr.crc  = crc16_byte(psr.crc, b);
        end else begin
          // no payload left: this byte is already the CRC low byte
          psr.crc_lo = b;
          psr.step   = STEP_CRC_HIGH;
        end
      end
      STEP_CRC_LOW: begin
        psr.crc_lo = b;
        psr.step   = STEP_CRC_HIGH;
      end
      STEP_CRC_HIGH: begin
        psr.crc_ok = ({b, psr.crc_lo} == psr.crc);
        psr.step   = STEP_END;
      end
      STEP_END: begin
        if (b == cfg_m.end_byte && psr.crc_ok) begin
          r.frame_status = STATUS_GOOD;
        end else begin
          r.frame_status = STATUS_BAD;
          psr.bad = psr.bad + 32'd1;
        end
        psr.idx  = '0;
        psr.step = STEP_HUNT;
      end
      default: begin
        psr.step = STEP_HUNT;
      end
    endcase
    r.stage       = psr.step;
    r.frame_cmd   = psr.cmd;
    r.frame_len   = psr.len;
    r.error_count = psr.bad;
    return r;
  endfunction

  function automatic void plan_byte(logic [BYTE_W-1:0] b);
    byte_plan_q.push_back('{is_cfg: 1'b0, idx: '0, val: b});
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
    byte_plan_q.push_back('{is_cfg: 1'b1, idx: idx, val: v});
    case (idx)
      CFG_START_BYTE: plan_cfg.start_byte = v;
      CFG_DEV_TYPE:   plan_cfg.dev_type   = v;
      CFG_DEV_ADDR:   plan_cfg.dev_addr   = v;
      CFG_END_BYTE:   plan_cfg.end_byte   = v;
      default: ;
    endcase
  endfunction

  // Queue one frame under the planned settings; fill < 0 means random payload
  function automatic void plan_frame(frame_kind_e kind, logic [BYTE_W-1:0] cmd,
                                     int len, int fill);
    logic [BYTE_W-1:0] body[$];
    logic [CRC_W-1:0]  crc;
    int                keep;
    body.push_back(plan_cfg.start_byte);
    if (kind == FR_BAD_TYPE) begin
      body.push_back(plan_cfg.dev_type ^ 8'($urandom_range(1, 255)));
    end else begin
      body.push_back(plan_cfg.dev_type);
      if (kind == FR_BAD_ADDR) begin
        body.push_back(plan_cfg.dev_addr ^ 8'($urandom_range(1, 255)));
      end else begin
        body.push_back(plan_cfg.dev_addr);
        body.push_back(cmd);
        body.push_back(8'(len));
        for (int k = 0; k < len; k++) begin
          body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        crc = '0;
        foreach (body[k]) begin
          crc = crc16_byte(crc, body[k]);
        end
        if (kind == FR_BAD_CRC) begin
          crc = crc ^ 16'($urandom_range(1, 65535));
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        body.push_back((kind == FR_BAD_END) ?
                       plan_cfg.end_byte ^ 8'($urandom_range(1, 255)) : plan_cfg.end_byte);
      end
    end
    keep = (kind == FR_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
    for (int k = 0; k < keep; k++) begin
      plan_byte(body[k]);
    end
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  function automatic void plan_traffic(int unsigned count, bit with_longest);
    int unsigned base;
    int unsigned pick;
    int          len;
    base = byte_plan_q.size();
    if (with_longest) begin
      plan_frame(FR_GOOD, 8'($urandom), 255, -1);
    end
    while (byte_plan_q.size() - base < count) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      if (pick < 58) begin
        plan_frame(FR_GOOD, 8'($urandom), len, -1);
      end else if (pick < 68) begin
        plan_frame(FR_BAD_CRC, 8'($urandom), len, -1);
      end else if (pick < 76) begin
        plan_frame(FR_BAD_END, 8'($urandom), len, -1);
      end else if (pick < 82) begin
        plan_frame(FR_BAD_TYPE, 8'($urandom), len, -1);
      end else if (pick < 87) begin
        plan_frame(FR_BAD_ADDR, 8'($urandom), len, -1);
      end else if (pick < 92) begin
        plan_frame(FR_CUT, 8'($urandom), len, -1);
      end else begin
        repeat ($urandom_range(1, 4)) plan_byte(8'($urandom));
      end
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      flag_mismatch($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
    end
  endfunction

  // Build the byte plan: directed frames first, then phases of traffic
  initial begin : stimulus
    plan_cfg = '{start_byte: START_BYTE_RST, dev_type: DEV_TYPE_RST,
                 dev_addr: DEV_ADDR_RST, end_byte: END_BYTE_RST};

    // zero-length frame, good
    plan_frame(FR_GOOD, 8'h00, 0, -1);
    // a second start byte where the type belongs drops back to hunting
    plan_byte(START_BYTE_RST);
    plan_byte(START_BYTE_RST);
    plan_frame(FR_BAD_ADDR, 8'h00, 0, -1);
    plan_byte(8'hFF);
    plan_byte(8'h00);
    // start byte as command and payload, then a wrong end byte
    plan_frame(FR_BAD_END, START_BYTE_RST, 1, START_BYTE_RST);

    plan_write(CFG_START_BYTE, 8'h00);
    plan_write(CFG_DEV_TYPE,   8'hFF);
    plan_write(CFG_DEV_ADDR,   8'h00);
    plan_write(CFG_END_BYTE,   8'hFF);
    plan_traffic(PHASE_ITEMS, 1'b0);

    plan_write(CFG_START_BYTE, 8'hFF);
    plan_write(CFG_DEV_TYPE,   8'h00);
    plan_write(CFG_DEV_ADDR,   8'hFF);
    plan_write(CFG_END_BYTE,   8'h00);
    plan_traffic(PHASE_ITEMS + 100, 1'b1);

    repeat (2) begin
      plan_write(CFG_START_BYTE, 8'($urandom));
      plan_write(CFG_DEV_TYPE,   8'($urandom));
      plan_write(CFG_DEV_ADDR,   8'($urandom));
      plan_write(CFG_END_BYTE,   8'($urandom));
      plan_traffic(PHASE_ITEMS, 1'b0);
    end

    plan_write(CFG_START_BYTE, START_BYTE_RST);
    plan_write(CFG_DEV_TYPE,   DEV_TYPE_RST);
    plan_write(CFG_DEV_ADDR,   DEV_ADDR_RST);
    plan_write(CFG_END_BYTE,   END_BYTE_RST);
    plan_traffic(PHASE_ITEMS, 1'b0);

    // wait for the plan to drain and every result to come back
    do @(posedge clk);
    while (byte_plan_q.size() != 0 || rx_if.valid || cfg_if.valid ||
           parse_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && parse_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hold off the result side for a long stretch while bytes keep coming
  initial begin : hold_off
    long_hold = 1'b0;
    do @(posedge clk);
    while (rx_taken < HOLD_AT);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Driver: offer planned bytes and register writes, with random gaps
  always @(posedge clk or negedge rst_n) begin : driver
    plan_item_t nxt;
    logic       rx_hold;
    logic       cfg_hold;
    if (!rst_n) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      cfg_if.valid  <= 1'b0;
      cfg_if.index  <= '0;
      cfg_if.data   <= '0;
      gap_left      <= 0;
      calm          <= 1'b0;
    end else begin
      calm     <= (byte_plan_q.size() < TAIL_ITEMS);
      rx_hold  = rx_if.valid && !rx_if.ready;
      cfg_hold = cfg_if.valid && !cfg_if.ready;
      if (!rx_hold && !cfg_hold && byte_plan_q.size() != 0) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (byte_plan_q[0].is_cfg) begin
          // write registers only once the block has gone quiet
          if (!rx_if.valid && !cfg_if.valid && settled >= SETTLE_CYCLES) begin
            nxt = byte_plan_q.pop_front();
            cfg_if.index <= nxt.idx;
            cfg_if.data  <= nxt.val;
            cfg_hold     = 1'b1;
          end
        end else begin
          nxt = byte_plan_q.pop_front();
          rx_if.rx_byte <= nxt.val;
          rx_hold       = 1'b1;
          if (!calm && (rx_taken % 256) < 170 && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(1, 16);
          end
        end
      end
      rx_if.valid  <= rx_hold;
      cfg_if.valid <= cfg_hold;
    end
  end

  // Monitor: predict on each byte transaction, check each result transaction
  always @(posedge clk or negedge rst_n) begin : monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
      rx_taken     <= 0;
      settled      <= 0;
      parse_results_q.delete();
      psr   = '{step: STEP_HUNT, left: '0, idx: '0, cmd: '0, len: '0, crc_lo: '0,
                crc_ok: 1'b0, crc: '0, bad: '0};
      cfg_m = '{start_byte: START_BYTE_RST, dev_type: DEV_TYPE_RST,
                dev_addr: DEV_ADDR_RST, end_byte: END_BYTE_RST};
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_results_q.push_back(parse_byte(rx_if.rx_byte));
        rx_taken <= rx_taken + 1;
      end

      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_START_BYTE: cfg_m.start_byte = cfg_if.data;
          CFG_DEV_TYPE:   cfg_m.dev_type   = cfg_if.data;
          CFG_DEV_ADDR:   cfg_m.dev_addr   = cfg_if.data;
          CFG_END_BYTE:   cfg_m.end_byte   = cfg_if.data;
          default: ;
        endcase
      end

      if (res_if.valid && res_if.ready) begin
        got = '{frame_status: res_if.frame_status, stage: res_if.stage,
                frame_cmd: res_if.frame_cmd, frame_len: res_if.frame_len,
                payload_valid: res_if.payload_valid, payload_byte: res_if.payload_byte,
                payload_index: res_if.payload_index, error_count: res_if.error_count};
        if (parse_results_q.size() == 0) begin
          flag_mismatch($sformatf("result with no byte pending, stage 0x%0h", got.stage));
        end else begin
          want = parse_results_q.pop_front();
          check_field("frame_status",  32'(want.frame_status),  32'(got.frame_status));
          check_field("stage",         32'(want.stage),         32'(got.stage));
          check_field("frame_cmd",     32'(want.frame_cmd),     32'(got.frame_cmd));
          check_field("frame_len",     32'(want.frame_len),     32'(got.frame_len));
          check_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
          check_field("payload_byte",  32'(want.payload_byte),  32'(got.payload_byte));
          check_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
          check_field("error_count",   want.error_count,        got.error_count);
        end
      end

      // count quiet cycles for the register write hold-off
      if (parse_results_q.size() != 0) begin
        settled <= 0;
      end else if (settled < 1000) begin
        settled <= settled + 1;
      end

      // random stall bursts, plus the long hold-off
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (!calm && (rx_taken % 256) >= 60 && $urandom_range(0, 9) == 0) begin
        stall_left   <= $urandom_range(0, 15);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !long_hold;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
